// File: rtl/lpfs_pkg.sv
// Package for the laser point frame sequencer.
// Widths, codes, transaction structs and small helpers shared by all rtl/ modules.
// No dependencies.
`default_nettype none

package lpfs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_W       = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 12;
  localparam int ENTRY_W    = 2 * COORD_W;
  localparam int CNT_W      = 16;
  localparam int LVL_W      = 8;

  localparam int FPS_W      = 10;
  localparam int PPS_W      = 16;
  localparam int TUS_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [FPS_W-1:0] FPS_RESET = FPS_W'(30);
  localparam logic [PPS_W-1:0] PPS_RESET = PPS_W'(30000);

  // frame sizing arithmetic
  localparam int DEN_PROD_W = FPS_W + PT_W;
  localparam int PROD_W     = TUS_W + PPS_W;
  localparam int DIV_NUM_W  = PPS_W + 2;
  localparam int DIV_DEN_W  = 22;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
  localparam int US_PER_S   = 1000000;

  // transition count: (prod + 500000) / 1e6 as a shift by 6 and a multiply by
  // the reciprocal of 15625; exact for shifted sums below 2^30, larger sums
  // saturate before the multiply is used
  localparam int BLANK_SUM_W  = PROD_W + 1;
  localparam int BLANK_PRE_SH = 6;
  localparam int BLANK_NUM_W  = 30;
  localparam int RECIP_W      = 31;
  localparam int RECIP_SH     = 44;
  localparam int BLANK_PROD_W = BLANK_NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0]     RECIP_15625 = 31'd1125899907;
  localparam logic [BLANK_SUM_W-1:0] BLANK_RND   = BLANK_SUM_W'(US_PER_S / 2);
  localparam logic [BLANK_SUM_W-1:0] BLANK_SAT   = BLANK_SUM_W'(64'(US_PER_S) << CNT_W);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_SAMPLE = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FPS       = 3'd0,
    REG_PPS       = 3'd1,
    REG_TRANS_US  = 3'd2,
    REG_RED       = 3'd3,
    REG_GREEN     = 3'd4,
    REG_BLUE      = 3'd5,
    REG_INTENSITY = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_SEP_GO,
    ST_SEP_WAIT,
    ST_BLANK_GO,
    ST_BLANK_WAIT,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    action_t              action;
    logic [COORD_W-1:0]   point_x;
    logic [COORD_W-1:0]   point_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]   laser_x;
    logic [COORD_W-1:0]   laser_y;
    logic [LVL_W-1:0]     red_out;
    logic [LVL_W-1:0]     green_out;
    logic [LVL_W-1:0]     blue_out;
    logic [LVL_W-1:0]     intensity_out;
    logic                 sample_valid;
    logic                 frame_end;
    logic [PT_W-1:0]      stored_points;
    logic                 push_dropped;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  // clip a quotient to the 16-bit count range
  function automatic logic [CNT_W-1:0] sat_count(input logic [DIV_NUM_W-1:0] q);
    logic [CNT_W-1:0] r;
    if (q[DIV_NUM_W-1:CNT_W] != '0) begin
      r = '1;
    end else begin
      r = q[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lpfs_point_ram.sv
// Point store: single write port, single read port, registered read data.
// Depends on lpfs_pkg for depth and entry width.
`default_nettype none

module lpfs_point_ram
  import lpfs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [ADDR_W-1:0]  raddr,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lpfs_divider.sv
// Restoring divider, one quotient bit per cycle, for frame sizing.
// Depends on lpfs_pkg for operand widths and the request struct.
`default_nettype none

module lpfs_divider
  import lpfs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire div_req_t             req,
  output logic                      done,
  output logic      [DIV_NUM_W-1:0] quot
);

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;
  logic [DIV_DEN_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, quot[DIV_NUM_W-1]};
    diff     = rem_sh - {1'b0, den};
    ge       = (rem_sh >= {1'b0, den});
    rem_next = ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quot <= req.num;
      den  <= req.den;
    end else if (run) begin
      rem  <= rem_next;
      quot <= {quot[DIV_NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/laser_point_frame_sequencer.sv
// Laser point frame sequencer, top level.
// Depends on lpfs_pkg, lpfs_point_ram and lpfs_divider.
//
// Usage:
//   A transaction is taken on start while busy is low; item carries the action
//   (push, pop, clear, next sample) and the point for a push. Exactly one
//   result comes back on result, marked by a one-cycle result_valid strobe;
//   busy drops in the same cycle, so the next start may follow at once.
//   Push, pop and clear answer from the execute state; a next-sample within a
//   frame adds one point-store read; the next-sample that starts a frame also
//   runs the 18-step bit-serial division for samples per point and then the
//   blanked transition count (shift, then reciprocal multiply) before the read.
//   One transaction is in flight at a time.
//   Registers are written through cfg_we/cfg_index/cfg_data; fps, pps and
//   transition writes take effect for the next frame, level writes at once.
//   Reset (rst, synchronous) empties the store, restarts the frame and loads
//   30 fps, 30000 pps, all else zero.
//   The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module laser_point_frame_sequencer
  import lpfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              item,
  output logic                       result_valid,
  output out_item_t                  result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [FPS_W-1:0] fps;
  logic [PPS_W-1:0] pps;
  logic [TUS_W-1:0] trans_us;
  logic [LVL_W-1:0] red_lvl;
  logic [LVL_W-1:0] green_lvl;
  logic [LVL_W-1:0] blue_lvl;
  logic [LVL_W-1:0] int_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      fps       <= FPS_RESET;
      pps       <= PPS_RESET;
      trans_us  <= '0;
      red_lvl   <= '0;
      green_lvl <= '0;
      blue_lvl  <= '0;
      int_lvl   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FPS:       fps       <= cfg_data[FPS_W-1:0];
        REG_PPS:       pps       <= cfg_data[PPS_W-1:0];
        REG_TRANS_US:  trans_us  <= cfg_data[TUS_W-1:0];
        REG_RED:       red_lvl   <= cfg_data[LVL_W-1:0];
        REG_GREEN:     green_lvl <= cfg_data[LVL_W-1:0];
        REG_BLUE:      blue_lvl  <= cfg_data[LVL_W-1:0];
        REG_INTENSITY: int_lvl   <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t                state;
  state_t                state_next;
  in_item_t              item_q;
  logic [PT_W-1:0]       total;
  logic [ADDR_W-1:0]     cur;
  logic [CNT_W-1:0]      sip;
  logic [CNT_W-1:0]      sep;
  logic [CNT_W-1:0]      blank_cnt;
  logic [DEN_PROD_W-1:0] den_q;
  logic [PROD_W-1:0]     prod_q;
  logic [BLANK_NUM_W-1:0] blank_num;
  logic                  blank_sat;

  logic                  full;
  logic                  frame_start;
  logic [FPS_W-1:0]      fps_eff;
  logic [PT_W-1:0]       total_edit;
  logic [CNT_W:0]        sip_inc;
  logic [PT_W-1:0]       cur_inc;
  logic                  point_done;
  logic                  last_point;
  logic                  blanked;
  logic                  mem_we;
  logic                  mem_re;
  logic [ENTRY_W-1:0]    mem_rdata;
  div_req_t              div_req;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  div_quot;
  logic [BLANK_SUM_W-1:0] blank_sum;
  logic [BLANK_PROD_W-1:0] blank_prod;
  out_item_t             edit_res;
  out_item_t             emit_res;

  lpfs_point_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (total[ADDR_W-1:0]),
    .wdata ({item_q.point_x, item_q.point_y}),
    .re    (mem_re),
    .raddr (cur),
    .rdata (mem_rdata)
  );

  lpfs_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  always_comb begin
    full        = (total == PT_W'(MAX_POINTS));
    frame_start = (cur == '0) && (sip == '0);
    fps_eff     = (fps == '0) ? FPS_W'(1) : fps;
    sip_inc     = {1'b0, sip} + 1'b1;
    cur_inc     = PT_W'(cur) + 1'b1;
    point_done  = (sip_inc >= {1'b0, sep});
    last_point  = (cur_inc >= total);
    blanked     = (total > PT_W'(1)) && (sip < blank_cnt);
    blank_sum   = {1'b0, prod_q} + BLANK_RND;
    blank_prod  = BLANK_PROD_W'(blank_num) * BLANK_PROD_W'(RECIP_15625);

    case (item_q.action)
      ACT_PUSH:  total_edit = full ? total : total + 1'b1;
      ACT_POP:   total_edit = (total == '0) ? total : total - 1'b1;
      default:   total_edit = '0;
    endcase

    edit_res               = '0;
    edit_res.stored_points = total_edit;
    edit_res.push_dropped  = (item_q.action == ACT_PUSH) && full;

    emit_res               = '0;
    emit_res.stored_points = total;
    if (sep != '0) begin
      emit_res.sample_valid = 1'b1;
      emit_res.frame_end    = point_done && ((total == '0) || last_point);
      if (total != '0) begin
        emit_res.laser_x = mem_rdata[ENTRY_W-1:COORD_W];
        emit_res.laser_y = mem_rdata[COORD_W-1:0];
        if (!blanked) begin
          emit_res.red_out       = red_lvl;
          emit_res.green_out     = green_lvl;
          emit_res.blue_out      = blue_lvl;
          emit_res.intensity_out = int_lvl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = (state != ST_IDLE);
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    div_req     = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_q.action != ACT_SAMPLE) begin
          mem_we     = (item_q.action == ACT_PUSH) && !full;
          state_next = ST_IDLE;
        end else if (frame_start) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_MUL: begin
        state_next = ST_SEP_GO;
      end
      ST_SEP_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'({pps, 1'b0}) + DIV_NUM_W'(den_q);
        div_req.den   = DIV_DEN_W'({den_q, 1'b0});
        state_next    = ST_SEP_WAIT;
      end
      ST_SEP_WAIT: begin
        if (div_done) begin
          state_next = ST_BLANK_GO;
        end
      end
      ST_BLANK_GO: begin
        state_next = ST_BLANK_WAIT;
      end
      ST_BLANK_WAIT: begin
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        mem_re     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      item_q <= item;
    end
    if (state == ST_MUL) begin
      den_q  <= (total == '0) ? DEN_PROD_W'(fps_eff)
                              : DEN_PROD_W'(fps_eff) * DEN_PROD_W'(total);
      prod_q <= PROD_W'(trans_us) * PROD_W'(pps);
    end
    if (state == ST_BLANK_GO) begin
      blank_num <= blank_sum[BLANK_PRE_SH +: BLANK_NUM_W];
      blank_sat <= (blank_sum >= BLANK_SAT);
    end
    if (state == ST_EXEC) begin
      result <= edit_res;
    end else if (state == ST_EMIT) begin
      result <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      cur          <= '0;
      sip          <= '0;
      sep          <= '0;
      blank_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_EXEC: begin
          if (item_q.action != ACT_SAMPLE) begin
            total        <= total_edit;
            cur          <= '0;
            sip          <= '0;
            result_valid <= 1'b1;
          end
        end
        ST_SEP_WAIT: begin
          if (div_done) begin
            sep <= sat_count(div_quot);
          end
        end
        ST_BLANK_WAIT: begin
          blank_cnt <= blank_sat ? '1 : blank_prod[RECIP_SH +: CNT_W];
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          if (sep != '0) begin
            if (point_done) begin
              sip <= '0;
              if (total != '0) begin
                cur <= last_point ? '0 : cur_inc[ADDR_W-1:0];
              end
            end else begin
              sip <= sip_inc[CNT_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.push_dropped) |-> (result.stored_points == PT_W'(MAX_POINTS)))
    else $error("push dropped while the store had room");

  a_frame_end_valid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_end) |-> result.sample_valid)
    else $error("frame end flagged on a result without a sample");

endmodule

`default_nettype wire

// File: bench/tb_laser_point_frame_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for laser_point_frame_sequencer: directed table, then random phases.
// Every transaction is predicted in-bench and each result strobe is checked field by field.
// Depends on lpfs_pkg and the rtl/ sources.

module tb_laser_point_frame_sequencer;
  import lpfs_pkg::*;

  typedef struct {
    bit                    is_cfg;
    cfg_reg_t              cfg_sel;
    logic [CFG_DATA_W-1:0] cfg_val;
    in_item_t              cmd;
    bit                    typed;
    out_item_t             want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              item = '0;
  logic                  result_valid;
  out_item_t             result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  laser_point_frame_sequencer u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // in-bench copy of the sequencer state and registers
  logic [ENTRY_W-1:0] point_mem [MAX_POINTS];
  int                 n_points = 0;
  int                 cur_point = 0;
  int                 pos_in_point = 0;
  int                 point_len = 0;
  int                 blank_len = 0;
  logic [FPS_W-1:0]   fps_cfg = FPS_RESET;
  logic [PPS_W-1:0]   pps_cfg = PPS_RESET;
  logic [TUS_W-1:0]   settle_us = '0;
  logic [LVL_W-1:0]   lvl_red = '0;
  logic [LVL_W-1:0]   lvl_green = '0;
  logic [LVL_W-1:0]   lvl_blue = '0;
  logic [LVL_W-1:0]   lvl_int = '0;

  out_item_t predicted[$];
  step_t     steps[$];
  int        errors = 0;
  bit        gaps_on = 1'b1;

  function automatic logic [CNT_W-1:0] div_round_sat(longint unsigned num,
                                                     longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 65535) ? 16'hFFFF : q[CNT_W-1:0];
  endfunction

  function automatic out_item_t sequence_step(in_item_t cmd);
    out_item_t          o;
    longint unsigned    fps_eff;
    longint unsigned    den;
    longint unsigned    prod;
    logic [ENTRY_W-1:0] entry;
    o = '0;
    if (cmd.action == ACT_SAMPLE) begin
      // frame sizing is latched only at frame start
      if (cur_point == 0 && pos_in_point == 0) begin
        fps_eff = (fps_cfg == 0) ? 1 : 64'(fps_cfg);
        den = (n_points == 0) ? fps_eff : fps_eff * 64'(n_points);
        point_len = div_round_sat(64'(pps_cfg), den);
        prod = 64'(settle_us) * 64'(pps_cfg);
        blank_len = div_round_sat(prod, US_PER_S);
      end
      if (point_len != 0) begin
        o.sample_valid = 1'b1;
        if (n_points != 0) begin
          entry = point_mem[cur_point];
          o.laser_x = entry[ENTRY_W-1:COORD_W];
          o.laser_y = entry[COORD_W-1:0];
          if (!(n_points > 1 && pos_in_point < blank_len)) begin
            o.red_out = lvl_red;
            o.green_out = lvl_green;
            o.blue_out = lvl_blue;
            o.intensity_out = lvl_int;
          end
        end
        pos_in_point++;
        if (pos_in_point >= point_len) begin
          pos_in_point = 0;
          if (n_points == 0) begin
            o.frame_end = 1'b1;
          end else begin
            cur_point++;
            if (cur_point >= n_points) begin
              cur_point = 0;
              o.frame_end = 1'b1;
            end
          end
        end
      end
    end else begin
      case (cmd.action)
        ACT_PUSH: begin
          if (n_points < MAX_POINTS) begin
            point_mem[n_points] = {cmd.point_x, cmd.point_y};
            n_points++;
          end else begin
            o.push_dropped = 1'b1;
          end
        end
        ACT_POP: begin
          if (n_points > 0) n_points--;
        end
        default: begin
          n_points = 0;
        end
      endcase
      cur_point = 0;
      pos_in_point = 0;
    end
    o.stored_points = PT_W'(n_points);
    return o;
  endfunction

  function automatic in_item_t mk_cmd(action_t a, logic [COORD_W-1:0] x,
                                      logic [COORD_W-1:0] y);
    in_item_t c;
    c.action = a;
    c.point_x = x;
    c.point_y = y;
    return c;
  endfunction

  function automatic in_item_t random_cmd(action_t a);
    return mk_cmd(a, COORD_W'($urandom), COORD_W'($urandom));
  endfunction

  // typed results here always have the drives at zero
  function automatic out_item_t mk_out(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                       logic valid, logic fend, int stored);
    out_item_t o;
    o = '0;
    o.laser_x = x;
    o.laser_y = y;
    o.sample_valid = valid;
    o.frame_end = fend;
    o.stored_points = PT_W'(stored);
    return o;
  endfunction

  function automatic step_t cfg_row(cfg_reg_t sel, int val);
    step_t s;
    s.is_cfg = 1'b1;
    s.cfg_sel = sel;
    s.cfg_val = CFG_DATA_W'(val);
    s.cmd = '0;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t item_row(action_t a, int x, int y, bit typed,
                                     out_item_t want);
    step_t s;
    s.is_cfg = 1'b0;
    s.cfg_sel = REG_FPS;
    s.cfg_val = '0;
    s.cmd = mk_cmd(a, COORD_W'(x), COORD_W'(y));
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    while (predicted.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_FPS:       fps_cfg = val[FPS_W-1:0];
      REG_PPS:       pps_cfg = val[PPS_W-1:0];
      REG_TRANS_US:  settle_us = val[TUS_W-1:0];
      REG_RED:       lvl_red = val[LVL_W-1:0];
      REG_GREEN:     lvl_green = val[LVL_W-1:0];
      REG_BLUE:      lvl_blue = val[LVL_W-1:0];
      REG_INTENSITY: lvl_int = val[LVL_W-1:0];
      default: ;
    endcase
  endtask

  // one transaction; returns at the accepting edge with start still high
  task automatic send_item(in_item_t cmd, bit typed, out_item_t want);
    int        gap;
    out_item_t model_out;
    gap = $urandom_range(0, 3);
    if (gaps_on && gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= cmd;
    do @(posedge clk); while (busy);
    model_out = sequence_step(cmd);
    predicted.push_back(typed ? want : model_out);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid) begin
      if (predicted.size() == 0) begin
        $error("result strobe with no transaction pending");
        errors++;
      end else begin
        want = predicted.pop_front();
        check_field("laser_x", want.laser_x, result.laser_x);
        check_field("laser_y", want.laser_y, result.laser_y);
        check_field("red_out", want.red_out, result.red_out);
        check_field("green_out", want.green_out, result.green_out);
        check_field("blue_out", want.blue_out, result.blue_out);
        check_field("intensity_out", want.intensity_out, result.intensity_out);
        check_field("sample_valid", want.sample_valid, result.sample_valid);
        check_field("frame_end", want.frame_end, result.frame_end);
        check_field("stored_points", want.stored_points, result.stored_points);
        check_field("push_dropped", want.push_dropped, result.push_dropped);
      end
    end
  end

  initial begin
    int       n_items;
    int       burst;
    int       kind;
    int       r;
    int       fps_v;
    int       pps_v;
    int       tus_v;
    action_t  act;

    // directed table; typed rows start from reset registers (30 fps, 30000 pps)
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 1, mk_out(0, 0, 1, 0, 0)));
    steps.push_back(item_row(ACT_POP, 4095, 4095, 1, mk_out(0, 0, 0, 0, 0)));
    steps.push_back(item_row(ACT_CLEAR, 0, 0, 1, mk_out(0, 0, 0, 0, 0)));
    steps.push_back(item_row(ACT_PUSH, 4095, 0, 1, mk_out(0, 0, 0, 0, 1)));
    steps.push_back(item_row(ACT_PUSH, 0, 4095, 1, mk_out(0, 0, 0, 0, 2)));
    steps.push_back(item_row(ACT_PUSH, 2048, 1, 1, mk_out(0, 0, 0, 0, 3)));
    steps.push_back(item_row(ACT_POP, 0, 0, 1, mk_out(0, 0, 0, 0, 2)));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 0, '0));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 0, '0));
    steps.push_back(cfg_row(REG_RED, 255));
    steps.push_back(cfg_row(REG_GREEN, 'h5A));
    steps.push_back(cfg_row(REG_BLUE, 1));
    steps.push_back(cfg_row(REG_INTENSITY, 'h80));
    steps.push_back(cfg_row(REG_TRANS_US, 1000000));
    steps.push_back(cfg_row(REG_PPS, 65535));
    steps.push_back(cfg_row(REG_FPS, 1000));
    // transition count is at its maximum: every sample of the frame is blanked
    steps.push_back(item_row(ACT_PUSH, 4095, 4095, 1, mk_out(0, 0, 0, 0, 3)));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 0, '0));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 0, '0));
    steps.push_back(cfg_row(REG_TRANS_US, 0));
    steps.push_back(item_row(ACT_CLEAR, 0, 0, 1, mk_out(0, 0, 0, 0, 0)));
    steps.push_back(item_row(ACT_PUSH, 1, 2, 1, mk_out(0, 0, 0, 0, 1)));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 0, '0));
    steps.push_back(item_row(ACT_POP, 0, 0, 1, mk_out(0, 0, 0, 0, 0)));
    // zero-length frame: no sample at all
    steps.push_back(cfg_row(REG_PPS, 0));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 1, mk_out(0, 0, 0, 0, 0)));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 1, mk_out(0, 0, 0, 0, 0)));
    // zero frame rate counts as one: one-sample empty frames
    steps.push_back(cfg_row(REG_FPS, 0));
    steps.push_back(cfg_row(REG_PPS, 1));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 1, mk_out(0, 0, 1, 1, 0)));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 1, mk_out(0, 0, 1, 1, 0)));
    steps.push_back(item_row(ACT_PUSH, 0, 0, 1, mk_out(0, 0, 0, 0, 1)));
    steps.push_back(item_row(ACT_SAMPLE, 0, 0, 0, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[k]) begin
      if (steps[k].is_cfg) begin
        write_reg(steps[k].cfg_sel, steps[k].cfg_val);
      end else begin
        send_item(steps[k].cmd, steps[k].typed, steps[k].want);
      end
    end

    n_items = 0;
    while (n_items < 880) begin
      kind = $urandom_range(0, 9);
      gaps_on = ($urandom_range(0, 3) != 0);
      case (kind)
        0: begin
          fps_v = $urandom_range(0, 1) ? 1000 : 1023;
          pps_v = 65535;
          tus_v = $urandom_range(0, 1) ? 1000000 : 'hFFFFF;
        end
        1: begin
          fps_v = $urandom_range(0, 1);
          pps_v = $urandom_range(0, 3);
          tus_v = 0;
        end
        default: begin
          // short frames so that frame ends and transitions come often
          fps_v = $urandom_range(1, 30);
          pps_v = $urandom_range(0, 120);
          tus_v = $urandom_range(0, 200000);
        end
      endcase
      write_reg(REG_FPS, CFG_DATA_W'(fps_v));
      write_reg(REG_PPS, CFG_DATA_W'(pps_v));
      write_reg(REG_TRANS_US, CFG_DATA_W'(tus_v));
      write_reg(REG_RED, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(REG_GREEN, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(REG_BLUE, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(REG_INTENSITY, CFG_DATA_W'($urandom_range(0, 255)));

      r = $urandom_range(0, 5);
      if (r == 0) begin
        // push a burst that can fill the store, so later pushes may be dropped
        burst = $urandom_range(60, 70);
        repeat (burst) send_item(random_cmd(ACT_PUSH), 0, '0);
        n_items += burst;
      end else if (r < 4) begin
        send_item(random_cmd(ACT_CLEAR), 0, '0);
        burst = $urandom_range(1, 8);
        repeat (burst) send_item(random_cmd(ACT_PUSH), 0, '0);
        n_items += burst + 1;
      end

      burst = $urandom_range(20, 50);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 72) act = ACT_SAMPLE;
        else if (r < 88) act = ACT_PUSH;
        else if (r < 97) act = ACT_POP;
        else act = ACT_CLEAR;
        send_item(random_cmd(act), 0, '0);
      end
      n_items += burst;
    end

    start <= 1'b0;
    while (predicted.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
